>>> hdl/ipc_pkg.sv
// Shared types and constants of the interrupt priority controller.
// Used by ipc_state, ipc_prio and the top level; it depends on nothing else.
package ipc_pkg;

   typedef enum logic {
      ACT_RAISE = 1'b0,
      ACT_ACK   = 1'b1
   } action_type;

   // Vector addresses, written in octal as the machine documents them.
   localparam logic [5:0] VEC_NONE          = 6'o00;
   localparam logic [5:0] VEC_CC_BASE       = 6'o22;
   localparam logic [5:0] VEC_CC_LAST       = 6'o37;
   localparam logic [5:0] VEC_UNIT_FIRST    = 6'o27;
   localparam logic [5:0] VEC_UNIT_LAST     = 6'o32;
   localparam logic [5:0] VEC_P2_BASE       = 6'o40;
   localparam logic [5:0] VEC_P2_ERR_LAST   = 6'o42;
   localparam logic [5:0] VEC_P2_CODE_FIRST = 6'o44;
   localparam logic [5:0] VEC_P2_CODE_LAST  = 6'o55;
   localparam logic [5:0] VEC_P1_BASE       = 6'o60;
   localparam logic [5:0] VEC_P1_ERR_LAST   = 6'o62;
   localparam logic [5:0] VEC_P1_CODE_FIRST = 6'o64;
   localparam logic [5:0] VEC_P1_CODE_LAST  = 6'o75;

   localparam int CC_FLAGS = 14;

   // Order in which the central flags are scanned, highest priority first.
   localparam logic [3:0] CHAIN_ORDER [CC_FLAGS] =
      '{4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd7, 4'd8,
        4'd3, 4'd4, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13};

   // Request beat payload; the last field sits in the lowest bits.
   typedef struct packed {
      logic [5:0]  pad;
      logic [3:0]  unit_mask_set;
      logic [3:0]  unit_busy_set;
      logic [63:0] pending_set;
      logic [5:0]  ack_vector;
      logic [3:0]  p2_code;
      logic [2:0]  p2_error_set;
      logic [3:0]  p1_code;
      logic [2:0]  p1_error_set;
      logic [13:0] cc_flag_set;
   } req_data_type;

   // Response beat payload; the last field sits in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic        illegal_vector;
      logic [3:0]  unit_mask;
      logic [3:0]  unit_busy;
      logic [63:0] pending_mask;
      logic [7:0]  p2_flags;
      logic [7:0]  p1_flags;
      logic [13:0] cc_flags;
      logic [5:0]  vector;
   } rsp_data_type;

   // Architectural interrupt state.
   typedef struct packed {
      logic [13:0] cc_flags;
      logic [7:0]  p1_flags;
      logic [7:0]  p2_flags;
      logic [63:0] pending;
      logic [3:0]  unit_busy;
      logic [3:0]  unit_mask;
   } irq_state_type;

endpackage

>>> hdl/ipc_state.sv
// Interrupt state registers and their update for one raise or acknowledge beat.
// Depends on ipc_pkg.
module ipc_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update_en,
   input  ipc_pkg::action_type   action,
   input  ipc_pkg::req_data_type req_data,
   output ipc_pkg::irq_state_type state_next,
   output logic                  illegal
);

   ipc_pkg::irq_state_type state_ff;
   logic [5:0]             v;

   assign v = req_data.ack_vector;

   always_comb begin
      state_next = state_ff;
      illegal    = 1'b0;
      if (action == ipc_pkg::ACT_RAISE) begin
         state_next.cc_flags  = state_ff.cc_flags | req_data.cc_flag_set;
         state_next.p1_flags  = state_ff.p1_flags | {5'b0, req_data.p1_error_set};
         if (req_data.p1_code != 4'b0) begin
            state_next.p1_flags[7:4] = req_data.p1_code;
         end
         state_next.p2_flags  = state_ff.p2_flags | {5'b0, req_data.p2_error_set};
         if (req_data.p2_code != 4'b0) begin
            state_next.p2_flags[7:4] = req_data.p2_code;
         end
         state_next.pending   = state_ff.pending | req_data.pending_set;
         state_next.unit_busy = state_ff.unit_busy | req_data.unit_busy_set;
         state_next.unit_mask = state_ff.unit_mask | req_data.unit_mask_set;
      end else if (v != ipc_pkg::VEC_NONE) begin
         state_next.pending = state_ff.pending & ~(64'(1) << v);
         if (v inside {[ipc_pkg::VEC_CC_BASE:ipc_pkg::VEC_CC_LAST]}) begin
            state_next.cc_flags = state_ff.cc_flags & ~(14'(1) << (v - ipc_pkg::VEC_CC_BASE));
            // The I/O-finished vectors also release their unit.
            if (v inside {[ipc_pkg::VEC_UNIT_FIRST:ipc_pkg::VEC_UNIT_LAST]}) begin
               state_next.unit_busy =
                  state_ff.unit_busy & ~(4'(1) << (v - ipc_pkg::VEC_UNIT_FIRST));
               state_next.unit_mask =
                  state_ff.unit_mask & ~(4'(1) << (v - ipc_pkg::VEC_UNIT_FIRST));
            end
         end else if (v inside {[ipc_pkg::VEC_P2_BASE:ipc_pkg::VEC_P2_ERR_LAST]}) begin
            state_next.p2_flags = state_ff.p2_flags & ~(8'(1) << (v - ipc_pkg::VEC_P2_BASE));
         end else if (v inside {[ipc_pkg::VEC_P2_CODE_FIRST:ipc_pkg::VEC_P2_CODE_LAST]}) begin
            state_next.p2_flags[7:4] = 4'b0;
         end else if (v inside {[ipc_pkg::VEC_P1_BASE:ipc_pkg::VEC_P1_ERR_LAST]}) begin
            state_next.p1_flags = state_ff.p1_flags & ~(8'(1) << (v - ipc_pkg::VEC_P1_BASE));
         end else if (v inside {[ipc_pkg::VEC_P1_CODE_FIRST:ipc_pkg::VEC_P1_CODE_LAST]}) begin
            state_next.p1_flags[7:4] = 4'b0;
         end else begin
            illegal = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update_en) begin
         state_ff <= state_next;
      end
   end

endmodule

>>> hdl/ipc_prio.sv
// Fixed priority chain that picks the vector to serve from the interrupt state.
// Depends on ipc_pkg.
module ipc_prio (
   input  ipc_pkg::irq_state_type state,
   output logic [5:0]             vector
);

   logic       cc_hit;
   logic [3:0] cc_bit;

   // Scan from lowest to highest priority so the highest one wins.
   always_comb begin
      cc_hit = 1'b0;
      cc_bit = 4'd0;
      for (int k = ipc_pkg::CC_FLAGS - 1; k >= 0; k--) begin
         if (state.cc_flags[ipc_pkg::CHAIN_ORDER[k]]) begin
            cc_hit = 1'b1;
            cc_bit = ipc_pkg::CHAIN_ORDER[k];
         end
      end
   end

   always_comb begin
      if (state.p1_flags[0]) begin
         vector = ipc_pkg::VEC_P1_BASE;
      end else if (state.p1_flags[1]) begin
         vector = ipc_pkg::VEC_P1_BASE + 6'd1;
      end else if (cc_hit) begin
         vector = ipc_pkg::VEC_CC_BASE + {2'b00, cc_bit};
      end else if (state.p1_flags[2]) begin
         vector = ipc_pkg::VEC_P1_ERR_LAST;
      end else if (state.p1_flags[7:4] != 4'b0) begin
         vector = ipc_pkg::VEC_P1_BASE + {2'b00, state.p1_flags[7:4]};
      end else if (state.p2_flags[0]) begin
         vector = ipc_pkg::VEC_P2_BASE;
      end else if (state.p2_flags[1]) begin
         vector = ipc_pkg::VEC_P2_BASE + 6'd1;
      end else if (state.p2_flags[2]) begin
         vector = ipc_pkg::VEC_P2_ERR_LAST;
      end else if (state.p2_flags[7:4] != 4'b0) begin
         vector = ipc_pkg::VEC_P2_BASE + {2'b00, state.p2_flags[7:4]};
      end else begin
         vector = ipc_pkg::VEC_NONE;
      end
   end

endmodule

>>> hdl/interrupt_priority_controller.sv
// Interrupt priority controller: an input register, the state update with the
// priority chain, and an output register. An accepted request beat waits in the
// input register until the output register loads its response; one beat is taken
// every cycle while the response side keeps up, req_tready following rsp_tready.
// Synchronous active-high reset clears all interrupt state and both valid flags.
// Depends on ipc_pkg, ipc_state and ipc_prio.
module interrupt_priority_controller (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [13:0] cc_flag_set, [16:14] p1_error_set, [20:17] p1_code,
   // [23:21] p2_error_set, [27:24] p2_code, [33:28] ack_vector,
   // [97:34] pending_set, [101:98] unit_busy_set, [105:102] unit_mask_set
   input  logic [111:0] req_tdata,
   // [0] action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [5:0] vector, [19:6] cc_flags, [27:20] p1_flags, [35:28] p2_flags,
   // [99:36] pending_mask, [103:100] unit_busy, [107:104] unit_mask,
   // [108] illegal_vector
   output logic [111:0] rsp_tdata
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   ipc_pkg::req_data_type  in_data_ff;
   ipc_pkg::action_type    in_action_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   ipc_pkg::rsp_data_type  out_data_ff;
   ipc_pkg::rsp_data_type  out_data_in;
   logic                   load;
   ipc_pkg::irq_state_type state_next;
   logic                   illegal;
   logic [5:0]             vector;

   // The held beat moves to the output register when that register is free
   // or is being emptied in this cycle.
   assign load       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || load;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !load);
   assign out_valid_in = load || (out_valid_ff && !rsp_tready);

   ipc_state u_state (
      .clock      (clock),
      .reset      (reset),
      .update_en  (load),
      .action     (in_action_ff),
      .req_data   (in_data_ff),
      .state_next (state_next),
      .illegal    (illegal)
   );

   ipc_prio u_prio (
      .state  (state_next),
      .vector (vector)
   );

   always_comb begin
      out_data_in                = '0;
      out_data_in.vector         = vector;
      out_data_in.cc_flags       = state_next.cc_flags;
      out_data_in.p1_flags       = state_next.p1_flags;
      out_data_in.p2_flags       = state_next.p2_flags;
      out_data_in.pending_mask   = state_next.pending;
      out_data_in.unit_busy      = state_next.unit_busy;
      out_data_in.unit_mask      = state_next.unit_mask;
      out_data_in.illegal_vector = illegal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff   <= ipc_pkg::req_data_type'(req_tdata);
         in_action_ff <= ipc_pkg::action_type'(req_tuser);
      end
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> hdl/ipc_checker.sv
// Port-level checks of the interrupt priority controller, bound to the top level.
// Depends only on the top level's ports.
module ipc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [111:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata
);

   // No response beat is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // When the output side can move, the block must take a new request.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled while output side is free");

   // A zero vector means no source is left in the processor or central flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[5:0] == 6'd0) ==
                      ((rsp_tdata[19:6] == 14'd0) && (rsp_tdata[27:20] == 8'd0) &&
                       (rsp_tdata[35:28] == 8'd0))))
      else $error("vector disagrees with pending sources");

endmodule

bind interrupt_priority_controller ipc_checker u_ipc_checker (.*);
